// ===== rtl/core/ptq_pkg.sv =====
package ptq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned ACTION_W        = 2;
	localparam int unsigned TASK_W          = 16;
	localparam int unsigned PRIO_W          = 16;
	localparam int unsigned STATUS_W        = 3;
	localparam int unsigned OCC_W           = 5;

	// action codes, the unused code is decoded as a pop
	localparam logic [ACTION_W-1:0] ACT_PUSH     = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_PRIO     = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_POP      = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_ALT  = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] STS_QUEUED   = 3'd0;
	localparam logic [STATUS_W-1:0] STS_REJECTED = 3'd1;
	localparam logic [STATUS_W-1:0] STS_POPPED   = 3'd2;
	localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] STS_FULL     = 3'd4;

	typedef struct packed {
		logic [ACTION_W-1:0]      action;
		logic [TASK_W-1:0]        task_id;
		logic signed [PRIO_W-1:0] priority_req;
		logic                     perform_first;
		logic                     prepare_ok;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [TASK_W-1:0]        out_task_id;
		logic signed [PRIO_W-1:0] out_priority;
		logic [OCC_W-1:0]         occupancy;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} ptq_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic cmp;
		logic upd;
	} ptq_cmd_t;

endpackage

// ===== rtl/core/ptq_ctrl.sv =====
module ptq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ptq_pkg::ptq_cmd_t cmd
);

	ptq_pkg::ptq_state_t state_q;
	ptq_pkg::ptq_state_t state_nx;
	logic                out_valid_q;
	logic                out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ptq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nx = ptq_pkg::ST_CMP;
				end
			end
			ptq_pkg::ST_CMP: begin
				state_nx = ptq_pkg::ST_UPD;
			end
			ptq_pkg::ST_UPD: begin
				if (out_free) begin
					state_nx = ptq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = ptq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ptq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ptq_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
			end
			ptq_pkg::ST_UPD: begin
				cmd.upd = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.upd) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a taken request always goes through compare and then update
	a_load_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ptq_pkg::ST_CMP)
		else $error("request not followed by compare");

	a_cmp_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptq_pkg::ST_CMP |=> state_q == ptq_pkg::ST_UPD)
		else $error("compare not followed by update");

	a_upd_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> out_valid_q && state_q == ptq_pkg::ST_IDLE)
		else $error("update did not present a result");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ptq_pkg::ST_IDLE |-> !cmd.load)
		else $error("request taken while busy");

endmodule

// ===== rtl/core/ptq_datapath.sv =====
module ptq_datapath #(
	parameter int unsigned QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ptq_pkg::ptq_cmd_t  cmd,
	input  ptq_pkg::in_item_t  in_data,
	output ptq_pkg::out_item_t out_data
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned LVL_N = $clog2(QUEUE_DEPTH);

	ptq_pkg::in_item_t        cmd_q;
	logic [ptq_pkg::TASK_W-1:0]        slot_task_q [QUEUE_DEPTH];
	logic signed [ptq_pkg::PRIO_W-1:0] slot_prio_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_nx;
	logic [QUEUE_DEPTH-1:0]   match_s1;
	logic [QUEUE_DEPTH-1:0]   pre_or [LVL_N+1];
	logic [QUEUE_DEPTH-1:0]   at_or_after;
	logic [QUEUE_DEPTH-1:0]   shift_up;
	logic [QUEUE_DEPTH-1:0]   at_pos;
	logic                     is_pop;
	logic                     push_ok;
	logic                     pop_ok;
	logic                     is_full;
	logic                     is_empty;
	ptq_pkg::out_item_t       res_q;

	assign is_pop   = (cmd_q.action == ptq_pkg::ACT_POP) || (cmd_q.action == ptq_pkg::ACT_POP_ALT);
	assign is_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	assign push_ok  = !is_pop && cmd_q.prepare_ok && !is_full;
	assign pop_ok   = is_pop && !is_empty;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_data;
		end
	end

	// per-slot compare, the slot at count always matches so a push
	// with no earlier hit lands at the back
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				match_s1[k] <= (CNT_W'(k) == count_q) ||
					((CNT_W'(k) < count_q) && (cmd_q.action == ptq_pkg::ACT_PRIO) &&
					 ((slot_prio_q[k] < cmd_q.priority_req) ||
					  (cmd_q.perform_first && slot_prio_q[k] == cmd_q.priority_req)));
			end
		end
	end

	// prefix or, log levels
	always_comb begin
		pre_or[0] = match_s1;
		for (int l = 0; l < LVL_N; l++) begin
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				if (k >= (1 << l)) begin
					pre_or[l+1][k] = pre_or[l][k] | pre_or[l][k - (1 << l)];
				end else begin
					pre_or[l+1][k] = pre_or[l][k];
				end
			end
		end
		at_or_after = pre_or[LVL_N];
		shift_up    = {at_or_after[QUEUE_DEPTH-2:0], 1'b0};
		at_pos      = at_or_after & ~shift_up;
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && push_ok) begin
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				if (k > 0 && shift_up[k]) begin
					slot_task_q[k] <= slot_task_q[(k > 0) ? k - 1 : 0];
					slot_prio_q[k] <= slot_prio_q[(k > 0) ? k - 1 : 0];
				end else if (at_pos[k]) begin
					slot_task_q[k] <= cmd_q.task_id;
					slot_prio_q[k] <= cmd_q.priority_req;
				end
			end
		end else if (cmd.upd && pop_ok) begin
			for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
				slot_task_q[k] <= slot_task_q[k+1];
				slot_prio_q[k] <= slot_prio_q[k+1];
			end
		end
	end

	always_comb begin
		count_nx = count_q;
		if (push_ok) begin
			count_nx = count_q + CNT_W'(1);
		end else if (pop_ok) begin
			count_nx = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.upd) begin
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			res_q.out_task_id  <= '0;
			res_q.out_priority <= '0;
			res_q.occupancy    <= ptq_pkg::OCC_W'(count_nx);
			if (is_pop) begin
				if (is_empty) begin
					res_q.status <= ptq_pkg::STS_EMPTY;
				end else begin
					res_q.status       <= ptq_pkg::STS_POPPED;
					res_q.out_task_id  <= slot_task_q[0];
					res_q.out_priority <= slot_prio_q[0];
				end
			end else if (!cmd_q.prepare_ok) begin
				res_q.status      <= ptq_pkg::STS_REJECTED;
				res_q.out_task_id <= cmd_q.task_id;
			end else if (is_full) begin
				res_q.status <= ptq_pkg::STS_FULL;
			end else begin
				res_q.status <= ptq_pkg::STS_QUEUED;
			end
		end
	end

	assign out_data = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("count beyond depth");

	a_one_insert_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd && push_ok |-> $onehot(at_pos))
		else $error("insert position not unique");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.upd |=> $stable(count_q))
		else $error("count moved outside update");

endmodule

// ===== rtl/core/priority_task_queue_unit.sv =====
// channel | direction | handshake               | payload
// in      | input     | in_valid / in_ready     | in_data  (action, task, priority, flags)
// out     | output    | out_valid / out_ready   | out_data (status, task, priority, occupancy)
//
// every request passes through capture, per-slot compare, then shift and insert
// the per-slot compare is registered before the shift and insert over the slot registers
// the result sits in an output register, so the next request is taken while it waits
// a new request stalls in update only while the previous result is still not taken
// reset clears the controller and the count, slot contents are left as they are
module priority_task_queue_unit #(
	parameter int unsigned QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ptq_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ptq_pkg::out_item_t out_data
);

	// commands from the sequencer to the slot datapath
	ptq_pkg::ptq_cmd_t cmd;

	// sequencer: idle, compare, update; owns the output valid
	ptq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// slot registers, per-slot priority compare, shift network and result register
	ptq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

	// every request yields exactly one result: no new request before the update is done
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("request accepted while one is in flight");

	a_result_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> out_valid)
		else $error("result missing after update");

	a_no_update_over_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> !out_valid || out_ready)
		else $error("result overwritten before taken");

endmodule

// ===== tb/sv/priority_task_queue_unit_tb.sv =====
module priority_task_queue_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ptq_pkg::*;

	localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;

	// random part: item count, the tail with no idling, and the long output hold-off
	localparam int RANDOM_REQS = 1000;
	localparam int CALM_TAIL   = 150;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 80;

	// one entry of the scheduler queue as the predictor keeps it, index 0 is the front
	typedef struct {
		logic [TASK_W-1:0]        tid;
		logic signed [PRIO_W-1:0] prio;
	} held_entry_t;

	// one row of the directed script, a typed result replaces the predicted one
	typedef struct {
		in_item_t  req;
		int        reps;
		bit        typed;
		out_item_t result;
	} script_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	held_entry_t held_tasks[$];
	out_item_t   expected_results[$];
	script_row_t directed_script[$];
	out_item_t   want_result;
	int          mismatches;
	int          requests_sent;
	bit          calm;
	bit          long_hold_done;

	priority_task_queue_unit #(
		.QUEUE_DEPTH(DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the block hangs on either handshake
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// scheduler queue behavior for one request, updates the held task list
	function automatic out_item_t predict_result(input in_item_t req);
		out_item_t   res;
		held_entry_t ent;
		int          slot;
		res = '0;
		if (req.action == ACT_POP || req.action == ACT_POP_ALT) begin
			// request fields other than the action do not matter on a pop
			if (held_tasks.size() == 0) begin
				res.status = STS_EMPTY;
			end else begin
				ent = held_tasks.pop_front();
				res.status       = STS_POPPED;
				res.out_task_id  = ent.tid;
				res.out_priority = ent.prio;
			end
		end else if (!req.prepare_ok) begin
			// unprepared task is echoed back, checked ahead of the full condition
			res.status      = STS_REJECTED;
			res.out_task_id = req.task_id;
		end else if (held_tasks.size() >= DEPTH) begin
			res.status = STS_FULL;
		end else begin
			slot = held_tasks.size();
			if (req.action == ACT_PRIO) begin
				// first entry of lower priority, or of equal priority when jumping ahead
				for (int k = 0; k < held_tasks.size(); k++) begin
					if (held_tasks[k].prio < req.priority_req ||
					    (req.perform_first && held_tasks[k].prio == req.priority_req)) begin
						slot = k;
						break;
					end
				end
			end
			ent.tid  = req.task_id;
			ent.prio = req.priority_req;
			held_tasks.insert(slot, ent);
			res.status = STS_QUEUED;
		end
		res.occupancy = OCC_W'(held_tasks.size());
		return res;
	endfunction

	function automatic script_row_t script_row(input logic [ACTION_W-1:0] act,
			input logic [TASK_W-1:0] tid, input logic [PRIO_W-1:0] prio,
			input bit ahead, input bit ok, input int reps, input bit typed,
			input logic [STATUS_W-1:0] st, input logic [TASK_W-1:0] res_tid,
			input logic [OCC_W-1:0] occ);
		script_row_t row;
		row.req.action        = act;
		row.req.task_id       = tid;
		row.req.priority_req  = prio;
		row.req.perform_first = ahead;
		row.req.prepare_ok    = ok;
		row.reps              = reps;
		row.typed             = typed;
		row.result            = '0;
		row.result.status     = st;
		row.result.out_task_id = res_tid;
		row.result.occupancy  = occ;
		return row;
	endfunction

	// append one row at the end of the directed script
	function automatic void add_row(input script_row_t row);
		directed_script.insert(directed_script.size(), row);
	endfunction

	// random request, push_pct sets how often it is a push rather than a pop
	function automatic in_item_t random_request(input int unsigned push_pct);
		in_item_t req;
		req.task_id = TASK_W'($urandom_range(0, 65535));
		case ($urandom_range(0, 3))
			0: begin
				req.priority_req = PRIO_W'($urandom_range(0, 65535));
			end
			1: begin
				req.priority_req = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			end
			default: begin
				// narrow band around zero so equal priorities are common
				req.priority_req = PRIO_W'($urandom_range(0, 6)) - 16'd3;
			end
		endcase
		req.perform_first = 1'($urandom_range(0, 1));
		req.prepare_ok    = ($urandom_range(0, 7) != 0);
		if ($urandom_range(0, 99) < push_pct) begin
			req.action = $urandom_range(0, 1) ? ACT_PRIO : ACT_PUSH;
		end else begin
			req.action = ($urandom_range(0, 7) == 0) ? ACT_POP_ALT : ACT_POP;
		end
		return req;
	endfunction

	// offer one request, record its expected result once it is taken
	task automatic offer_request(input in_item_t req, input bit typed,
			input out_item_t typed_result);
		out_item_t predicted;
		if (!calm && $urandom_range(0, 3) == 0) begin
			// idle burst before this request
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 9)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = predict_result(req);
		expected_results.insert(expected_results.size(), typed ? typed_result : predicted);
		requests_sent++;
	endtask

	// result side: random stall bursts, one long hold-off to back the queue up
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!long_hold_done && requests_sent >= HOLD_AT) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				long_hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result checker, compares each taken result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: status %0d task %0h",
				       out_data.status, out_data.out_task_id);
				mismatches++;
			end else begin
				want_result = expected_results.pop_front();
				if (out_data.status !== want_result.status) begin
					$error("status: expected %0d actual %0d",
					       want_result.status, out_data.status);
					mismatches++;
				end
				if (out_data.out_task_id !== want_result.out_task_id) begin
					$error("out_task_id: expected %0h actual %0h",
					       want_result.out_task_id, out_data.out_task_id);
					mismatches++;
				end
				if (out_data.out_priority !== want_result.out_priority) begin
					$error("out_priority: expected %0d actual %0d",
					       want_result.out_priority, out_data.out_priority);
					mismatches++;
				end
				if (out_data.occupancy !== want_result.occupancy) begin
					$error("occupancy: expected %0d actual %0d",
					       want_result.occupancy, out_data.occupancy);
					mismatches++;
				end
			end
		end
	end

	initial begin
		in_valid       = 1'b0;
		in_data        = '0;
		arst_n         = 1'b0;
		requests_sent  = 0;
		calm           = 1'b0;

		// pops on an empty queue, both pop codes, the alternate one with every field set
		add_row(script_row(ACT_POP, 16'h0000, 16'h0000, 1'b0, 1'b0, 1,
			1'b1, STS_EMPTY, 16'h0000, 5'd0));
		add_row(script_row(ACT_POP_ALT, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1,
			1'b1, STS_EMPTY, 16'h0000, 5'd0));
		// unprepared tasks are echoed and not stored
		add_row(script_row(ACT_PUSH, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1,
			1'b1, STS_REJECTED, 16'hFFFF, 5'd0));
		add_row(script_row(ACT_PRIO, 16'h1234, 16'h7FFF, 1'b0, 1'b0, 1,
			1'b1, STS_REJECTED, 16'h1234, 5'd0));
		add_row(script_row(ACT_PUSH, 16'hFFFF, 16'h7FFF, 1'b0, 1'b1, 1,
			1'b1, STS_QUEUED, 16'h0000, 5'd1));
		// priority pushes at the extremes, behind and ahead of equal priorities
		add_row(script_row(ACT_PRIO, 16'h0000, 16'h8000, 1'b0, 1'b1, 1,
			1'b0, STS_QUEUED, 16'h0000, 5'd0));
		add_row(script_row(ACT_PRIO, 16'h0101, 16'h7FFF, 1'b0, 1'b1, 1,
			1'b0, STS_QUEUED, 16'h0000, 5'd0));
		add_row(script_row(ACT_PRIO, 16'h0202, 16'h7FFF, 1'b1, 1'b1, 1,
			1'b0, STS_QUEUED, 16'h0000, 5'd0));
		add_row(script_row(ACT_PRIO, 16'h0303, 16'h0000, 1'b0, 1'b1, 1,
			1'b0, STS_QUEUED, 16'h0000, 5'd0));
		add_row(script_row(ACT_PRIO, 16'h0404, 16'h0000, 1'b1, 1'b1, 1,
			1'b0, STS_QUEUED, 16'h0000, 5'd0));
		// plain push ignores priority, then a lowest priority push that finds no slot
		add_row(script_row(ACT_PUSH, 16'h0505, 16'h0064, 1'b1, 1'b1, 1,
			1'b0, STS_QUEUED, 16'h0000, 5'd0));
		add_row(script_row(ACT_PRIO, 16'h0606, 16'h8000, 1'b0, 1'b1, 1,
			1'b0, STS_QUEUED, 16'h0000, 5'd0));
		add_row(script_row(ACT_PRIO, 16'h0A0A, 16'h0005, 1'b0, 1'b1, 8,
			1'b0, STS_QUEUED, 16'h0000, 5'd0));
		// full queue drops pushes, but the unprepared check still wins
		add_row(script_row(ACT_PUSH, 16'hBEEF, 16'h1111, 1'b0, 1'b1, 1,
			1'b1, STS_FULL, 16'h0000, 5'(DEPTH)));
		add_row(script_row(ACT_PRIO, 16'hCAFE, 16'h7FFF, 1'b1, 1'b1, 1,
			1'b1, STS_FULL, 16'h0000, 5'(DEPTH)));
		add_row(script_row(ACT_PUSH, 16'h7777, 16'h0000, 1'b0, 1'b0, 1,
			1'b1, STS_REJECTED, 16'h7777, 5'(DEPTH)));
		// drain everything, the last pop through the alternate code with junk fields
		add_row(script_row(ACT_POP, 16'h5A5A, 16'hA5A5, 1'b1, 1'b0, 15,
			1'b0, STS_QUEUED, 16'h0000, 5'd0));
		add_row(script_row(ACT_POP_ALT, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1,
			1'b0, STS_QUEUED, 16'h0000, 5'd0));
		add_row(script_row(ACT_POP, 16'h0000, 16'h0000, 1'b0, 1'b1, 1,
			1'b1, STS_EMPTY, 16'h0000, 5'd0));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_script[r]) begin
			repeat (directed_script[r].reps) begin
				offer_request(directed_script[r].req, directed_script[r].typed,
				              directed_script[r].result);
			end
		end

		// random part in phases: push heavy to fill, pop heavy to drain, then balanced
		for (int i = 0; i < RANDOM_REQS; i++) begin
			calm = (i >= RANDOM_REQS - CALM_TAIL);
			case ((i / 50) % 3)
				0: offer_request(random_request(85), 1'b0, '0);
				1: offer_request(random_request(20), 1'b0, '0);
				default: offer_request(random_request(55), 1'b0, '0);
			endcase
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// let the pipeline drain and watch for stray results
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== priority_task_queue_unit.f =====
rtl/core/ptq_pkg.sv
rtl/core/ptq_ctrl.sv
rtl/core/ptq_datapath.sv
rtl/core/priority_task_queue_unit.sv
tb/sv/priority_task_queue_unit_tb.sv
